// ===== rtl/etf_pkg.sv =====
package etf_pkg;

  // Frame geometry
  localparam int PERIOD_W  = 16;
  localparam int DUTY_W    = 8;
  localparam int MANT_W    = 9;
  localparam int EXP_W     = 3;
  localparam int WORD_W    = MANT_W + EXP_W;
  localparam int NIB_W     = 4;
  localparam int FRAME_W   = WORD_W + NIB_W;
  localparam int GCR_SYM_W = 5;
  localparam int GCR_W     = (FRAME_W / NIB_W) * GCR_SYM_W;
  localparam int SLOTS     = GCR_W + 2;
  localparam int SLOT_W    = $clog2(SLOTS);

  localparam logic [SLOT_W-1:0] LAST_SLOT_IDX = SLOT_W'(SLOTS - 1);
  localparam logic [DUTY_W-1:0] HIGH_DUTY_RST = DUTY_W'(160);

  // Queue between encoder and serialiser
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [GCR_W-1:0] gcr_word_t;

  // Queue head as seen by the serialiser
  typedef struct packed {
    logic      valid;
    gcr_word_t gcr;
  } etf_head_t;

  // Nibble to 5-bit GCR symbol
  function automatic logic [GCR_SYM_W-1:0] gcr_code(input logic [NIB_W-1:0] nib);
    logic [GCR_SYM_W-1:0] c;
    case (nib)
      4'h0: c = 5'h19;
      4'h1: c = 5'h1B;
      4'h2: c = 5'h12;
      4'h3: c = 5'h13;
      4'h4: c = 5'h1D;
      4'h5: c = 5'h15;
      4'h6: c = 5'h16;
      4'h7: c = 5'h17;
      4'h8: c = 5'h1A;
      4'h9: c = 5'h09;
      4'hA: c = 5'h0A;
      4'hB: c = 5'h0B;
      4'hC: c = 5'h1E;
      4'hD: c = 5'h0D;
      4'hE: c = 5'h0E;
      4'hF: c = 5'h0F;
      default: c = 5'h0F;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/erpm_telemetry_frame_encoder.sv =====
// Channel   | Valid        | Stall        | Payload
// ----------+--------------+--------------+---------------------
// input     | period_valid | period_stall | period
// output    | slot_valid   | slot_stall   | slot_duty, last_slot
// config    | high_duty_we | -            | high_duty
//
// Each period gives 22 output slots, one per cycle unless slot_stall holds the output;
// the slot serialiser limits the sustained period rate.
// The encoder converts a period in the cycle it is transferred and parks it in a
// two-entry queue, so input stalls only when the queue is full.
// Synchronous reset empties queue and output stage and sets high_duty to 160.
// Output stall freezes the serialiser; frames run back to back with no gap.
module erpm_telemetry_frame_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           high_duty_we,
  input  logic [etf_pkg::DUTY_W-1:0]     high_duty,
  input  logic                           period_valid,
  output logic                           period_stall,
  input  logic [etf_pkg::PERIOD_W-1:0]   period,
  output logic                           slot_valid,
  input  logic                           slot_stall,
  output logic [etf_pkg::DUTY_W-1:0]     slot_duty,
  output logic                           last_slot
);
  import etf_pkg::*;

  logic [DUTY_W-1:0] duty_cfg;
  logic              q_full;
  logic              q_push;
  gcr_word_t         q_data;
  logic              q_pop;
  etf_head_t         q_head;

  // Duty register
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_cfg <= HIGH_DUTY_RST;
    end else if (high_duty_we) begin
      duty_cfg <= high_duty;
    end
  end

  etf_front u_front (
    .period_valid (period_valid),
    .period_stall (period_stall),
    .period       (period),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  etf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  etf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .duty_cfg   (duty_cfg),
    .head       (q_head),
    .pop        (q_pop),
    .slot_valid (slot_valid),
    .slot_stall (slot_stall),
    .slot_duty  (slot_duty),
    .last_slot  (last_slot)
  );

endmodule

// ===== rtl/etf_queue.sv =====
module etf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  etf_pkg::gcr_word_t push_data,
  output logic               full,
  input  logic               pop,
  output etf_pkg::etf_head_t head
);
  import etf_pkg::*;

  gcr_word_t          mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.gcr   = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/etf_front.sv =====
module etf_front (
  input  logic                            period_valid,
  output logic                            period_stall,
  input  logic [etf_pkg::PERIOD_W-1:0]    period,
  input  logic                            q_full,
  output logic                            q_push,
  output etf_pkg::gcr_word_t              q_data
);
  import etf_pkg::*;

  logic [EXP_W-1:0]   expo;
  logic [PERIOD_W-1:0] shifted;
  logic [WORD_W-1:0]  word;
  logic [NIB_W-1:0]   chk;
  logic [FRAME_W-1:0] frame;

  // Exponent: shifts needed to fit the period into 9 bits
  always_comb begin
    expo = '0;
    for (int i = MANT_W; i < PERIOD_W; i++) begin
      if (period[i]) expo = EXP_W'(i - MANT_W + 1);
    end
  end

  // Pack, checksum, GCR map
  always_comb begin
    shifted = period >> expo;
    word    = {expo, shifted[MANT_W-1:0]};
    chk     = ~(word[3:0] ^ word[7:4] ^ word[11:8]);
    frame   = {word, chk};
    q_data  = {gcr_code(frame[15:12]), gcr_code(frame[11:8]),
               gcr_code(frame[7:4]),   gcr_code(frame[3:0])};
  end

  // Transfer into the queue whenever there is room
  assign period_stall = q_full;
  assign q_push       = period_valid && !q_full;

endmodule

// ===== rtl/etf_back.sv =====
module etf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [etf_pkg::DUTY_W-1:0]   duty_cfg,
  input  etf_pkg::etf_head_t           head,
  output logic                         pop,
  output logic                         slot_valid,
  input  logic                         slot_stall,
  output logic [etf_pkg::DUTY_W-1:0]   slot_duty,
  output logic                         last_slot
);
  import etf_pkg::*;

  logic              active;
  logic [SLOT_W-1:0] cnt;
  gcr_word_t         sr;
  logic              level;
  logic              advance;
  logic              level_next;

  assign advance    = !slot_valid || !slot_stall;
  assign level_next = level ^ sr[GCR_W-1];
  assign pop        = advance && !active && head.valid;

  // Serialiser: one slot per transfer, next frame follows without a gap
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      slot_valid <= 1'b0;
      cnt        <= '0;
      last_slot  <= 1'b0;
    end else if (advance) begin
      if (active) begin
        slot_valid <= 1'b1;
        if (cnt == LAST_SLOT_IDX) begin
          slot_duty <= '0;
          last_slot <= 1'b1;
          active    <= 1'b0;
        end else begin
          slot_duty <= level_next ? '0 : duty_cfg;
          last_slot <= 1'b0;
          level     <= level_next;
          sr        <= sr << 1;
          cnt       <= cnt + 1'b1;
        end
      end else if (head.valid) begin
        // start level is always low
        slot_valid <= 1'b1;
        slot_duty  <= duty_cfg;
        last_slot  <= 1'b0;
        sr         <= head.gcr;
        level      <= 1'b0;
        cnt        <= SLOT_W'(1);
        active     <= 1'b1;
      end else begin
        slot_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/erpm_frame_checker.sv =====
module erpm_frame_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         high_duty_we,
  input  logic [etf_pkg::DUTY_W-1:0]   high_duty,
  input  logic                         period_valid,
  input  logic                         period_stall,
  input  logic [etf_pkg::PERIOD_W-1:0] period,
  input  logic                         slot_valid,
  input  logic                         slot_stall,
  input  logic [etf_pkg::DUTY_W-1:0]   slot_duty,
  input  logic                         last_slot,
  output int                           fail_count,
  output int                           slots_due,
  output int                           slots_seen
);
  import etf_pkg::*;

  // GCR symbols, nibble 15 in the top five bits down to nibble 0
  localparam logic [79:0] GCR_SYMS = {
    5'h0F, 5'h0E, 5'h0D, 5'h1E, 5'h0B, 5'h0A, 5'h09, 5'h1A,
    5'h17, 5'h16, 5'h15, 5'h1D, 5'h13, 5'h12, 5'h1B, 5'h19
  };

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              last;
  } line_slot_t;

  line_slot_t        due_slots [$];
  line_slot_t        head_slot;
  logic [DUTY_W-1:0] duty_reg;

  // Period -> exponent/mantissa word -> checksum -> GCR -> line levels.
  // Bit 19 is the level after the first GCR bit; the start level is 0.
  function automatic logic [19:0] encode_levels(input logic [PERIOD_W-1:0] p);
    logic [PERIOD_W-1:0] v;
    logic [2:0]          e;
    logic [11:0]         word;
    logic [3:0]          chk;
    logic [15:0]         frm;
    logic [19:0]         sym;
    logic [19:0]         lvls;
    logic                lvl;
    v = p;
    e = '0;
    if (v[15:9] != '0) begin
      while (v > 16'h01FF) begin
        v = v >> 1;
        e = e + 3'd1;
      end
    end
    word = {e, v[8:0]};
    chk  = ~(word[3:0] ^ word[7:4] ^ word[11:8]);
    frm  = {word, chk};
    sym  = {GCR_SYMS[frm[15:12]*5 +: 5], GCR_SYMS[frm[11:8]*5 +: 5],
            GCR_SYMS[frm[7:4]*5 +: 5], GCR_SYMS[frm[3:0]*5 +: 5]};
    lvl  = 1'b0;
    for (int i = 19; i >= 0; i--) begin
      lvl     = lvl ^ sym[i];
      lvls[i] = lvl;
    end
    return lvls;
  endfunction

  // Push the whole frame: start slot, 20 level slots, closing zero slot
  task automatic queue_frame(input logic [PERIOD_W-1:0] p);
    logic [19:0] lv;
    line_slot_t  s;
    lv     = encode_levels(p);
    s.last = 1'b0;
    s.duty = duty_reg;
    due_slots.push_back(s);
    for (int k = 19; k >= 0; k--) begin
      s.duty = lv[k] ? '0 : duty_reg;
      due_slots.push_back(s);
    end
    s.duty = '0;
    s.last = 1'b1;
    due_slots.push_back(s);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Everything is sampled at the rising edge; inputs move on the falling one
  always @(posedge clk) begin
    if (rst) begin
      due_slots.delete();
      duty_reg   = HIGH_DUTY_RST;
      fail_count = 0;
      slots_seen = 0;
      slots_due  = 0;
    end else begin
      if (high_duty_we)
        duty_reg = high_duty;
      if (period_valid && !period_stall)
        queue_frame(period);
      if (slot_valid && !slot_stall) begin
        if (due_slots.size() == 0) begin
          report_mismatch($sformatf("slot transfer (duty %0d last %0b) with none pending",
                                    slot_duty, last_slot));
        end else begin
          head_slot = due_slots.pop_front();
          if (slot_duty !== head_slot.duty)
            report_mismatch($sformatf("slot %0d: slot_duty %0d, predicted %0d",
                                      slots_seen, slot_duty, head_slot.duty));
          if (last_slot !== head_slot.last)
            report_mismatch($sformatf("slot %0d: last_slot %0b, predicted %0b",
                                      slots_seen, last_slot, head_slot.last));
        end
        slots_seen++;
      end
      slots_due = due_slots.size();
    end
  end

endmodule

// ===== tb/erpm_telemetry_frame_encoder_tb.sv =====
module erpm_telemetry_frame_encoder_tb;
  import etf_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                high_duty_we = 1'b0;
  logic [DUTY_W-1:0]   high_duty    = '0;
  logic                period_valid = 1'b0;
  logic [PERIOD_W-1:0] period       = '0;
  logic                slot_stall   = 1'b0;
  logic                period_stall;
  logic                slot_valid;
  logic [DUTY_W-1:0]   slot_duty;
  logic                last_slot;

  int chk_fails;
  int chk_due;
  int chk_seen;

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int periods_sent  = 0;
  int duty_settings = 1;
  int quiet_cycles  = 0;

  erpm_telemetry_frame_encoder DUT (
    .clk          (clk),
    .rst          (rst),
    .high_duty_we (high_duty_we),
    .high_duty    (high_duty),
    .period_valid (period_valid),
    .period_stall (period_stall),
    .period       (period),
    .slot_valid   (slot_valid),
    .slot_stall   (slot_stall),
    .slot_duty    (slot_duty),
    .last_slot    (last_slot)
  );

  erpm_frame_checker frame_chk (
    .clk          (clk),
    .rst          (rst),
    .high_duty_we (high_duty_we),
    .high_duty    (high_duty),
    .period_valid (period_valid),
    .period_stall (period_stall),
    .period       (period),
    .slot_valid   (slot_valid),
    .slot_stall   (slot_stall),
    .slot_duty    (slot_duty),
    .last_slot    (last_slot),
    .fail_count   (chk_fails),
    .slots_due    (chk_due),
    .slots_seen   (chk_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall, or a long hold-off when the sender asks for one
  initial begin
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        repeat (HOLD_CYCLES) begin
          slot_stall <= 1'b1;
          @(negedge clk);
        end
      end
      slot_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((period_valid && !period_stall) || (slot_valid && !slot_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d slots still due",
                 quiet_cycles, chk_due);
        $display("erpm_telemetry_frame_encoder_tb: errors");
        $finish;
      end
    end
  end

  // Spread periods over all eight exponents, with some fully random words
  function automatic logic [PERIOD_W-1:0] pick_period();
    int e;
    if ($urandom_range(0, 9) == 0)
      return PERIOD_W'($urandom);
    e = $urandom_range(0, 7);
    if (e == 0)
      return PERIOD_W'($urandom_range(0, 511));
    return PERIOD_W'($urandom_range(1 << (8 + e), (1 << (9 + e)) - 1));
  endfunction

  // One period transfer; called and returns on a falling edge
  task automatic offer_period(input logic [PERIOD_W-1:0] p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      period_valid <= 1'b0;
      @(negedge clk);
    end
    period_valid <= 1'b1;
    period       <= p;
    do @(posedge clk); while (period_stall);
    @(negedge clk);
    periods_sent++;
  endtask

  // Stop offering and wait for every predicted slot to come out
  task automatic drain_frames();
    period_valid <= 1'b0;
    while (chk_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_high_duty(input logic [DUTY_W-1:0] v);
    drain_frames();
    high_duty_we <= 1'b1;
    high_duty    <= v;
    @(negedge clk);
    high_duty_we <= 1'b0;
    duty_settings++;
  endtask

  task automatic random_periods(input int n, input int tx_pct, input int rx_pct,
                                input bit long_hold, input bit mid_drain);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        if (long_hold)
          hold_reqs++;
        if (mid_drain)
          drain_frames();
      end
      offer_period(pick_period());
    end
  endtask

  initial begin
    logic [PERIOD_W-1:0] corners [18];
    corners = '{16'd0, 16'd1, 16'd255, 16'd256, 16'd511, 16'd512, 16'd513,
                16'd1023, 16'd1024, 16'd2047, 16'd4095, 16'd8191, 16'd16383,
                16'd32767, 16'd32768, 16'h5555, 16'hAAAA, 16'hFFFF};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset duty: corner periods, then random ones; slow receiver
    tx_idle_pct = 13;
    rx_idle_pct = 77;
    foreach (corners[i])
      offer_period(corners[i]);
    random_periods(82, 13, 77, 1'b0, 1'b0);

    // Zero duty, slow sender
    set_high_duty(8'd0);
    random_periods(70, 77, 13, 1'b0, 1'b0);

    // Full-scale duty, no idling, long receiver hold-off mid-phase
    set_high_duty(8'd255);
    random_periods(70, 0, 0, 1'b1, 1'b0);

    // Duty at half the reset value, sender pauses mid-phase until the output has drained
    set_high_duty(8'd80);
    random_periods(40, 0, 0, 1'b0, 1'b1);

    set_high_duty(DUTY_W'($urandom_range(1, 254)));
    random_periods(30, 0, 0, 1'b0, 1'b0);

    drain_frames();
    repeat (30) @(negedge clk);

    $display("Run covered %0d periods (corners and all exponents) at %0d high_duty settings,",
             periods_sent, duty_settings);
    $display("with sender and receiver idling, a long hold-off; %0d slots compared.",
             chk_seen);
    if (chk_fails == 0 && chk_due == 0)
      $display("erpm_telemetry_frame_encoder_tb: clean");
    else
      $display("erpm_telemetry_frame_encoder_tb: errors");
    $finish;
  end

endmodule
